[design/wwoc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wwoc_pkg
// shared types and constants of the whole-word occurrence counter
// ----------------------------------------------------------------------------
package wwoc_pkg;

    localparam int BYTE_W      = 8;
    localparam int PAT_W       = 64;
    localparam int LEN_REG_W   = 5;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 5;
    localparam int COUNT_OUT_W = 16;
    localparam int QUEUE_DEPTH = 2;

    // register index, taken from paddr above the 8-byte lane bits
    typedef enum logic [1:0] {
        REG_PAT_LO  = 2'd0,
        REG_PAT_HI  = 2'd1,
        REG_PAT_LEN = 2'd2
    } cfg_index_t;

    // one classified text byte on its way from the front to the back
    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              letter;
        logic              final_byte;
    } q_item_t;

endpackage : wwoc_pkg
`default_nettype wire

[design/whole_word_occurrence_counter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// whole_word_occurrence_counter
// counts whole-word occurrences of a configured pattern in a byte stream
// ----------------------------------------------------------------------------
// usage
//   text channel: text_valid/text_stall carry one text byte per transfer with
//   final_byte marking the last byte of a text
//   count channel: count_valid/count_stall carry occurrence_count, one
//   transfer per text, sent for its final byte
//   registers (apb, 8-byte spacing): pattern bytes 0..7, pattern bytes 8..15,
//   pattern length; write only while no text is in flight
// timing
//   one text byte per cycle sustained while no held count stalls a final byte;
//   the whole window is compared against the pattern in parallel in the back end
//   count_valid is registered: it rises once the back end takes the final byte
//   out of the queue
//   a two-entry queue sits between the input stage and the matcher
// reset
//   pattern clears to zero with length one, queue and tally empty
// stall
//   a held count blocks only the next final byte; other bytes keep flowing
//   until the queue fills, then text_stall rises
// ----------------------------------------------------------------------------
module whole_word_occurrence_counter
    import wwoc_pkg::*;
#(
    parameter int WORD_MAX    = 16,
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [CFG_ADDR_W-1:0]  paddr,
    input  wire logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]       prdata,
    output logic                        pready,
    input  wire logic                   text_valid,
    output logic                        text_stall,
    input  wire logic [BYTE_W-1:0]      text_byte,
    input  wire logic                   final_byte,
    output logic                        count_valid,
    input  wire logic                   count_stall,
    output logic [COUNT_OUT_W-1:0]      occurrence_count
);

    logic [PAT_W-1:0]     pat_lo_reg, pat_lo_next;
    logic [PAT_W-1:0]     pat_hi_reg, pat_hi_next;
    logic [LEN_REG_W-1:0] pat_len_reg, pat_len_next;
    logic                 cfg_write;
    cfg_index_t           cfg_sel;

    logic                 item_valid;
    q_item_t              item;
    logic                 item_pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = cfg_index_t'(paddr[CFG_ADDR_W-1:3]);

    always_comb
    begin
        pat_lo_next  = pat_lo_reg;
        pat_hi_next  = pat_hi_reg;
        pat_len_next = pat_len_reg;
        if (cfg_write)
        begin
            case (cfg_sel)
                REG_PAT_LO:  pat_lo_next  = pwdata;
                REG_PAT_HI:  pat_hi_next  = pwdata;
                REG_PAT_LEN: pat_len_next = pwdata[LEN_REG_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_PAT_LO:  prdata = pat_lo_reg;
            REG_PAT_HI:  prdata = pat_hi_reg;
            REG_PAT_LEN: prdata = CFG_DATA_W'(pat_len_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg  <= '0;
            pat_hi_reg  <= '0;
            pat_len_reg <= LEN_REG_W'(1);
        end
        else
        begin
            pat_lo_reg  <= pat_lo_next;
            pat_hi_reg  <= pat_hi_next;
            pat_len_reg <= pat_len_next;
        end
    end

    wwoc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    wwoc_back #(
        .WORD_MAX    (WORD_MAX),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .pattern_lo       (pat_lo_reg),
        .pattern_hi       (pat_hi_reg),
        .pattern_len      (pat_len_reg),
        .item_valid       (item_valid),
        .item             (item),
        .item_pop         (item_pop),
        .count_valid      (count_valid),
        .count_stall      (count_stall),
        .occurrence_count (occurrence_count)
    );

endmodule : whole_word_occurrence_counter
`default_nettype wire

[design/wwoc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wwoc_front
// accepts text bytes, marks ascii letters and queues them for the back end
// ----------------------------------------------------------------------------
module wwoc_front
    import wwoc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              text_valid,
    output logic                   text_stall,
    input  wire logic [BYTE_W-1:0] text_byte,
    input  wire logic              final_byte,
    output logic                   item_valid,
    output q_item_t                item,
    input  wire logic              item_pop
);

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    q_item_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push;
    logic              pop;
    q_item_t           new_item;

    function automatic logic is_letter(input logic [BYTE_W-1:0] c);
        return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
    endfunction

    assign text_stall = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign push       = text_valid && !text_stall;
    assign item_valid = (cnt_reg != '0);
    assign pop        = item_pop && item_valid;
    assign item       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.text_byte  = text_byte;
        new_item.letter     = is_letter(text_byte);
        new_item.final_byte = final_byte;
    end

    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = QCNT_W'(cnt_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            cnt_next = QCNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule : wwoc_front
`default_nettype wire

[design/wwoc_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wwoc_back
// holds the byte window, decides whole-word matches and keeps the tally
// ----------------------------------------------------------------------------
module wwoc_back
    import wwoc_pkg::*;
#(
    parameter int WORD_MAX    = 16,
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [PAT_W-1:0]       pattern_lo,
    input  wire logic [PAT_W-1:0]       pattern_hi,
    input  wire logic [LEN_REG_W-1:0]   pattern_len,
    input  wire logic                   item_valid,
    input  wire q_item_t                item,
    output logic                        item_pop,
    output logic                        count_valid,
    input  wire logic                   count_stall,
    output logic [COUNT_OUT_W-1:0]      occurrence_count
);

    localparam int WIN    = WORD_MAX + 1;
    localparam int LEN_W  = $clog2(WORD_MAX + 1);
    localparam int SEEN_W = $clog2(WORD_MAX + 2);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [WIN*BYTE_W-1:0]  bytes_reg, bytes_next;
    logic [WIN-1:0]         lets_reg, lets_next;
    logic [SEEN_W-1:0]      seen_reg, seen_next;
    logic [COUNT_WIDTH-1:0] tally_reg, tally_next;
    logic                   valid_reg, valid_next;
    logic [COUNT_OUT_W-1:0] count_reg, count_next;

    logic [2*PAT_W-1:0]     pattern_all;
    logic [LEN_REG_W-1:0]   len_clip;
    logic [LEN_W-1:0]       eff_len;
    logic [WIN*BYTE_W-1:0]  shift_bytes;
    logic [WIN-1:0]         shift_lets;
    logic [SEEN_W-1:0]      shift_seen;
    logic                   match_old;
    logic                   match_new;
    logic [COUNT_WIDTH-1:0] tally_a;
    logic [COUNT_WIDTH-1:0] tally_b;
    logic [31:0]            tally_wide;
    logic                   pop;

    // pattern ends at the newest byte of the window with no letter before it
    function automatic logic match_at(
        input logic [WIN*BYTE_W-1:0] wbytes,
        input logic [WIN-1:0]        wlets,
        input logic [SEEN_W-1:0]     seen,
        input logic [LEN_W-1:0]      len,
        input logic [2*PAT_W-1:0]    pat
    );
        logic       ok;
        logic [3:0] pidx;
        ok = (len != '0) && (seen >= SEEN_W'(len));
        for (int i = 0; i < WORD_MAX; i++)
        begin
            if (i < int'(len))
            begin
                pidx = 4'(int'(len) - 1 - i);
                if (wbytes[i*BYTE_W +: BYTE_W] != pat[pidx*BYTE_W +: BYTE_W])
                begin
                    ok = 1'b0;
                end
            end
        end
        if ((seen > SEEN_W'(len)) && wlets[len])
        begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] bump(
        input logic [COUNT_WIDTH-1:0] t,
        input logic                   hit
    );
        return (hit && (t != COUNT_MAX)) ? COUNT_WIDTH'(t + 1'b1) : t;
    endfunction

    // a final byte waits only when an earlier count is still held
    assign pop      = item_valid && (!item.final_byte || !valid_reg || !count_stall);
    assign item_pop = pop;

    always_comb
    begin
        pattern_all = {pattern_hi, pattern_lo};
        len_clip    = (pattern_len > LEN_REG_W'(WORD_MAX)) ? LEN_REG_W'(WORD_MAX)
                                                           : pattern_len;
        eff_len     = len_clip[LEN_W-1:0];

        shift_bytes = {bytes_reg[(WIN-1)*BYTE_W-1:0], item.text_byte};
        shift_lets  = {lets_reg[WIN-2:0], item.letter};
        shift_seen  = (seen_reg < SEEN_W'(WIN)) ? SEEN_W'(seen_reg + 1'b1) : seen_reg;

        // candidate before this byte, then the end of text after it
        match_old   = match_at(bytes_reg, lets_reg, seen_reg, eff_len, pattern_all);
        match_new   = match_at(shift_bytes, shift_lets, shift_seen, eff_len, pattern_all);

        tally_a     = bump(tally_reg, match_old && !item.letter);
        tally_b     = bump(tally_a, match_new && item.final_byte);
        tally_wide  = 32'(tally_b);
    end

    always_comb
    begin
        bytes_next = bytes_reg;
        lets_next  = lets_reg;
        seen_next  = seen_reg;
        tally_next = tally_reg;
        count_next = count_reg;
        valid_next = valid_reg && count_stall;
        if (pop)
        begin
            bytes_next = shift_bytes;
            lets_next  = shift_lets;
            if (item.final_byte)
            begin
                seen_next  = '0;
                tally_next = '0;
                count_next = tally_wide[COUNT_OUT_W-1:0];
                valid_next = 1'b1;
            end
            else
            begin
                seen_next  = shift_seen;
                tally_next = tally_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            tally_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg  <= seen_next;
            tally_reg <= tally_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        lets_reg  <= lets_next;
        count_reg <= count_next;
    end

    assign count_valid      = valid_reg;
    assign occurrence_count = count_reg;

`ifndef NO_ASSERTIONS
    a_result_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg) |-> $past(pop && item.final_byte))
        else $error("count presented without a final byte");

    a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= SEEN_W'(WIN))
        else $error("byte count beyond the window");

    a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && item.final_byte) |=> (seen_reg == '0) && (tally_reg == '0))
        else $error("state not cleared after final byte");

    a_no_drop_of_held: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && count_stall) |-> !(pop && item.final_byte))
        else $error("held count overwritten");
`endif

endmodule : wwoc_back
`default_nettype wire
